### hdl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEFT_W    = 2;
    localparam int unsigned QDEPTH    = 3;
    localparam int unsigned QCNT_W    = 2;

    localparam logic [CP_W-1:0] CP_MAX            = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO           = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI           = 21'h00DFFF;
    localparam logic [CP_W-1:0] RESET_REPLACEMENT = 21'h00005F;  // '_'

    // One decoded result as held in the output queue
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            was_error;
        logic            run_last;
        logic            string_done;
    } result_t;

endpackage

### hdl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-wise UTF-8 decoder with error substitution and end-of-string flush.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | data_byte[7:0], end_of_string
//  output  | out_valid / out_ready| code_point[20:0], was_error, run_last,
//          |                      | string_done
//  config  | cfg_valid / cfg_ready| replacement_char[20:0]
//
//  One byte is taken per cycle while in_ready is high, and results leave
//  one per cycle while out_ready is high. Decode is a single shallow pass
//  from the input port into a three-entry result queue. in_ready decodes
//  the count register: high while at most one word is queued, so a byte
//  whose two results would not fit is held off. A one-result byte streams
//  at one word per cycle with out_ready high; a two-result byte holds off
//  the next byte until one word is left. rst_n clears the open sequence,
//  the queue and sets replacement_char to '_'. cfg_ready is always high.
//
module utf8_stream_decoder_top
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_string,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic              was_error,
    output logic              run_last,
    output logic              string_done,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CP_W-1:0]   replacement_char
);

    // Decoder state
    logic [CP_W-1:0]   repl_reg;
    logic [CP_W-1:0]   partial_reg,  partial_next;
    logic [LEFT_W-1:0] left_reg,     left_next;

    // Result queue, head at entry 0
    result_t           queue_reg [QDEPTH];
    result_t           queue_next [QDEPTH];
    logic [QCNT_W-1:0] count_reg,    count_next;

    // Decode outputs for the accepted byte
    result_t           res0, res1;
    logic [1:0]        num_res;

    logic              accept;
    logic              pop;
    logic              is_cont;
    logic [CP_W-1:0]   joined;
    logic              bad_value;
    logic [QCNT_W-1:0] base;

    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg <= QCNT_W'(1));

    assign out_valid   = (count_reg != '0);
    assign code_point  = queue_reg[0].code_point;
    assign was_error   = queue_reg[0].was_error;
    assign run_last    = queue_reg[0].run_last;
    assign string_done = queue_reg[0].string_done;

    assign is_cont   = (data_byte[7:6] == 2'b10);
    assign joined    = {partial_reg[CP_W-7:0], data_byte[5:0]};
    assign bad_value = (joined > CP_MAX) || (joined >= SURR_LO && joined <= SURR_HI);

    // ------------------------------------------------------------------
    // Decode: up to two results per byte, in order res0, res1
    // ------------------------------------------------------------------
    always_comb
    begin
        logic            restart;
        logic            emit_a;
        logic            err_a;
        logic [CP_W-1:0] cp_a;
        logic            emit_b;
        logic            err_b;
        logic [CP_W-1:0] cp_b;
        logic            emit_c;

        restart      = 1'b0;
        emit_a       = 1'b0;
        err_a        = 1'b0;
        cp_a         = '0;
        emit_b       = 1'b0;
        err_b        = 1'b0;
        cp_b         = '0;
        emit_c       = 1'b0;
        partial_next = partial_reg;
        left_next    = left_reg;

        // Open sequence: extend it or break it
        if (left_reg != '0)
        begin
            if (is_cont)
            begin
                partial_next = joined;
                left_next    = left_reg - LEFT_W'(1);
                if (left_reg == LEFT_W'(1))
                begin
                    emit_a       = 1'b1;
                    err_a        = bad_value;
                    cp_a         = bad_value ? repl_reg : joined;
                    partial_next = '0;
                end
            end
            else
            begin
                emit_a       = 1'b1;
                err_a        = 1'b1;
                cp_a         = repl_reg;
                partial_next = '0;
                left_next    = '0;
                restart      = 1'b1;
            end
        end
        else
        begin
            restart = 1'b1;
        end

        // Byte taken as a lead
        if (restart)
        begin
            if (!data_byte[7])
            begin
                emit_b = 1'b1;
                cp_b   = CP_W'(data_byte);
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                partial_next = CP_W'(data_byte[4:0]);
                left_next    = LEFT_W'(1);
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                partial_next = CP_W'(data_byte[3:0]);
                left_next    = LEFT_W'(2);
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                partial_next = CP_W'(data_byte[2:0]);
                left_next    = LEFT_W'(3);
            end
            else
            begin
                // lone continuation or 0xF8 and up
                emit_b = 1'b1;
                err_b  = 1'b1;
                cp_b   = repl_reg;
            end
        end

        // End of string flushes an open sequence
        if (end_of_string && left_next != '0)
        begin
            emit_c       = 1'b1;
            partial_next = '0;
            left_next    = '0;
        end

        // Pack in order; at most two of the three are ever set
        res0    = '0;
        res1    = '0;
        num_res = 2'd0;
        if (emit_a)
        begin
            res0    = '{code_point: cp_a, was_error: err_a, run_last: 1'b0,
                        string_done: 1'b0};
            num_res = 2'd1;
            if (emit_b)
            begin
                res1    = '{code_point: cp_b, was_error: err_b, run_last: 1'b0,
                            string_done: 1'b0};
                num_res = 2'd2;
            end
            else if (emit_c)
            begin
                res1    = '{code_point: repl_reg, was_error: 1'b1, run_last: 1'b0,
                            string_done: 1'b0};
                num_res = 2'd2;
            end
        end
        else if (emit_b)
        begin
            res0    = '{code_point: cp_b, was_error: err_b, run_last: 1'b0,
                        string_done: 1'b0};
            num_res = 2'd1;
        end
        else if (emit_c)
        begin
            res0    = '{code_point: repl_reg, was_error: 1'b1, run_last: 1'b0,
                        string_done: 1'b0};
            num_res = 2'd1;
        end

        if (num_res == 2'd2)
        begin
            res1.run_last    = 1'b1;
            res1.string_done = end_of_string;
        end
        else
        begin
            res0.run_last    = 1'b1;
            res0.string_done = end_of_string;
        end
    end

    // ------------------------------------------------------------------
    // Queue update: shift out on pop, append new results behind
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [1:0] pushed;

        pushed = accept ? num_res : 2'd0;
        base   = count_reg - QCNT_W'(pop);

        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && i < QDEPTH - 1)
                queue_next[i] = queue_reg[i+1];
            else
                queue_next[i] = queue_reg[i];

            if (pushed != 2'd0 && base == QCNT_W'(i))
                queue_next[i] = res0;
            if (pushed == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i))
                queue_next[i] = res1;
        end

        count_next = base + QCNT_W'(pushed);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg    <= RESET_REPLACEMENT;
            partial_reg <= '0;
            left_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                repl_reg <= replacement_char;
            if (accept)
            begin
                partial_reg <= partial_next;
                left_reg    <= left_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

`ifndef SYNTHESIS
    // A byte is only taken when both of its possible results fit
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> count_reg <= QCNT_W'(1))
        else $error("byte accepted without queue room");

    // End of string always leaves no open sequence
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> left_reg == '0)
        else $error("sequence left open after end of string");

    // End of string always produces a final word
    a_eos_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> out_valid)
        else $error("end of string gave no result");

    // The final word of a string closes its byte's run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> run_last)
        else $error("string_done without run_last");
`endif

endmodule
